// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check samples on the rising
// clock edge and is disabled while the reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks one property.
`define ASSERT_AT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(name, pre, post, msg) \
  `ASSERT_AT(name, (pre) |-> (post), msg)

`endif

// ----- rtl/core/pmfb_pkg.sv -----
`default_nettype none

package pmfb_pkg;

  // Default screen geometry.
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  // Field widths.
  localparam int ACT_W   = 3;
  localparam int COORD_W = 16;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 4;
  localparam int IDX_W   = 10;
  localparam int GH_W    = 7;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 6;
  localparam int BIT_W   = 3;

  // Limits on the pixel count and the glyph height.
  localparam logic [COUNT_W-1:0] MAX_BITS   = 4'd8;
  localparam logic [GH_W-1:0]    GH_MIN     = 7'd1;
  localparam logic [GH_W-1:0]    GH_MAX     = 7'd64;
  localparam logic [GH_W-1:0]    GH_RESET   = 7'd8;
  localparam logic [BIT_W-1:0]   GLYPH_MSB  = 3'd7;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET    = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_COLUMN = 3'd2,
    ACT_GLYPH  = 3'd3,
    ACT_FILL   = 3'd4,
    ACT_READ   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_RMW,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_e;

  // Clip result and bit position of one pixel.
  typedef struct packed {
    logic             on_screen;
    logic [BIT_W-1:0] bit_sel;
  } pix_info_t;

endpackage

`default_nettype wire

// ----- rtl/core/pmfb_store.sv -----
`default_nettype none

module pmfb_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [pmfb_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  output logic      [pmfb_pkg::BYTE_W-1:0] rdata_o
);
  import pmfb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/pmfb_pix_unit.sv -----
`default_nettype none

// Clips one pixel coordinate to the screen and maps it to a store byte and bit.
module pmfb_pix_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int ADDR_W        = 10
) (
  input  wire logic [pmfb_pkg::COORD_W-1:0] px_i,
  input  wire logic [pmfb_pkg::COORD_W-1:0] py_i,
  output logic      [ADDR_W-1:0]            addr_o,
  output pmfb_pkg::pix_info_t               info_o
);
  import pmfb_pkg::*;

  localparam int StoreBytes = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
  localparam int AFW        = ADDR_W + 1;
  localparam int XW         = $clog2(SCREEN_WIDTH);
  localparam int YW         = ($clog2(SCREEN_HEIGHT) > 4) ? $clog2(SCREEN_HEIGHT) : 4;

  logic           x_in;
  logic           y_in;
  logic [AFW-1:0] addr_full;

  // Bounds checks on the full 16-bit coordinates.
  assign x_in = px_i < COORD_W'(SCREEN_WIDTH);
  assign y_in = py_i < COORD_W'(SCREEN_HEIGHT);

  // Page times width plus column; only meaningful once both checks pass.
  assign addr_full = AFW'(py_i[YW-1:3]) * AFW'(SCREEN_WIDTH) + AFW'(px_i[XW-1:0]);

  assign addr_o           = addr_full[ADDR_W-1:0];
  assign info_o.on_screen = x_in && y_in && (addr_full < AFW'(StoreBytes));
  assign info_o.bit_sel   = py_i[BIT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/page_mode_pixel_framebuffer.sv -----
// Steps from accept to result: set or clear go through ST_PIX, then ST_RMW unless clipped;
// column and glyph bytes visit ST_PIX per pixel, up to eight, and ST_RMW per on-screen
// pixel; an in-range read goes through ST_READ; fill writes every store byte; the rest go
// straight to ST_DONE, which waits while a held result is stalled. One item at a time: the
// next is taken in the cycle after the result loads. After reset the store is swept to zero,
// one byte a cycle (1024 at the default geometry), with in_stall_o held high.
`default_nettype none

`include "assert_macros.svh"

module page_mode_pixel_framebuffer #(
  parameter int SCREEN_WIDTH  = pmfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pmfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [pmfb_pkg::GH_W-1:0]    cfg_data_i,
  // Input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pmfb_pkg::ACT_W-1:0]   action_i,
  input  wire logic [pmfb_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic [pmfb_pkg::COORD_W-1:0] y_coord_i,
  input  wire logic [pmfb_pkg::BYTE_W-1:0]  source_byte_i,
  input  wire logic [pmfb_pkg::COUNT_W-1:0] bit_count_i,
  input  wire logic                         first_of_glyph_i,
  input  wire logic [pmfb_pkg::IDX_W-1:0]   byte_index_i,
  // Output channel.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [pmfb_pkg::BYTE_W-1:0]  read_data_o,
  output logic      [pmfb_pkg::COUNT_W-1:0] pixels_inside_o
);
  import pmfb_pkg::*;

  localparam int StoreBytes = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
  localparam int AW         = $clog2(StoreBytes);
  localparam logic [AW-1:0] LastAddr = AW'(StoreBytes - 1);

  // Control state.
  state_e             state_q, state_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic [GH_W-1:0]    gh_q, gh_d;
  logic [COORD_W-1:0] ox_q, ox_d;
  logic [COORD_W-1:0] oy_q, oy_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               out_valid_q, out_valid_d;

  // Item payload and working registers.
  action_e            act_q, act_d;
  logic [COORD_W-1:0] x_q, x_d;
  logic [COORD_W-1:0] y_q, y_d;
  logic [BYTE_W-1:0]  src_q, src_d;
  logic [COUNT_W-1:0] n_q, n_d;
  logic [COUNT_W-1:0] b_q, b_d;
  logic [COUNT_W-1:0] inside_q, inside_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic               on_q, on_d;
  logic [BYTE_W-1:0]  rd_q, rd_d;
  logic [BYTE_W-1:0]  read_data_q, read_data_d;
  logic [COUNT_W-1:0] pixels_inside_q, pixels_inside_d;

  // Store port signals.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [BYTE_W-1:0]  mem_rdata;

  // Shared pixel unit signals.
  logic [COORD_W-1:0] pix_x;
  logic [COORD_W-1:0] pix_y;
  logic [AW-1:0]      pix_addr;
  pix_info_t          pix_info;
  logic               pix_on;

  // Step bookkeeping.
  logic [GH_W-1:0]    gh_eff;
  logic [GH_W-1:0]    row_inc;
  logic [ROW_W-1:0]   row_adv;
  logic [COL_W-1:0]   col_adv;
  logic [COUNT_W-1:0] b_next;
  logic [COORD_W-1:0] idx_ext;
  logic [BYTE_W-1:0]  mask;

  pmfb_store #(
    .DEPTH  (StoreBytes),
    .ADDR_W (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pmfb_pix_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (AW)
  ) u_pix (
    .px_i   (pix_x),
    .py_i   (pix_y),
    .addr_o (pix_addr),
    .info_o (pix_info)
  );

  // Coordinate and pixel value of the current step.
  always_comb begin
    case (act_q)
      ACT_COLUMN: begin
        pix_x  = x_q;
        pix_y  = y_q + COORD_W'(b_q);
        pix_on = src_q[b_q[BIT_W-1:0]];
      end
      ACT_GLYPH: begin
        pix_x  = ox_q + COORD_W'(col_q);
        pix_y  = oy_q + COORD_W'(row_q);
        pix_on = src_q[GLYPH_MSB - b_q[BIT_W-1:0]];
      end
      default: begin
        pix_x  = x_q;
        pix_y  = y_q;
        pix_on = (act_q == ACT_SET);
      end
    endcase
  end

  // Glyph cursor advance, with the height clamped to its legal range.
  always_comb begin
    if (gh_q < GH_MIN) begin
      gh_eff = GH_MIN;
    end else if (gh_q > GH_MAX) begin
      gh_eff = GH_MAX;
    end else begin
      gh_eff = gh_q;
    end
    row_inc = GH_W'(row_q) + GH_W'(1);
    if (row_inc >= gh_eff) begin
      row_adv = '0;
      col_adv = col_q + COL_W'(1);
    end else begin
      row_adv = row_inc[ROW_W-1:0];
      col_adv = col_q;
    end
  end

  assign b_next  = b_q + COUNT_W'(1);
  assign idx_ext = COORD_W'(byte_index_i);
  assign mask    = BYTE_W'(1) << bit_q;

  // Sequencer: next state, store ports and register updates.
  always_comb begin
    state_d         = state_q;
    sweep_d         = sweep_q;
    gh_d            = gh_q;
    ox_d            = ox_q;
    oy_d            = oy_q;
    col_d           = col_q;
    row_d           = row_q;
    out_valid_d     = out_valid_q;
    act_d           = act_q;
    x_d             = x_q;
    y_d             = y_q;
    src_d           = src_q;
    n_d             = n_q;
    b_d             = b_q;
    inside_d        = inside_q;
    addr_d          = addr_q;
    bit_d           = bit_q;
    on_d            = on_q;
    rd_d            = rd_q;
    read_data_d     = read_data_q;
    pixels_inside_d = pixels_inside_q;
    mem_we          = 1'b0;
    mem_waddr       = sweep_q;
    mem_wdata       = '0;
    mem_raddr       = pix_addr;

    if (cfg_valid_i) begin
      gh_d = cfg_data_i;
    end

    // The result register empties once its beat is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (sweep_q == LastAddr) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_IDLE: begin
        mem_raddr = idx_ext[AW-1:0];
        if (in_valid_i) begin
          act_d    = action_e'(action_i);
          x_d      = x_coord_i;
          y_d      = y_coord_i;
          src_d    = source_byte_i;
          b_d      = '0;
          inside_d = '0;
          rd_d     = '0;
          n_d      = COUNT_W'(1);
          case (action_e'(action_i))
            ACT_SET, ACT_CLEAR: begin
              state_d = ST_PIX;
            end
            ACT_COLUMN: begin
              n_d = (bit_count_i > MAX_BITS) ? MAX_BITS : bit_count_i;
              state_d = (bit_count_i == '0) ? ST_DONE : ST_PIX;
            end
            ACT_GLYPH: begin
              n_d = MAX_BITS;
              if (first_of_glyph_i) begin
                ox_d  = x_coord_i;
                oy_d  = y_coord_i;
                col_d = '0;
                row_d = '0;
              end
              state_d = ST_PIX;
            end
            ACT_FILL: begin
              sweep_d = '0;
              state_d = ST_FILL;
            end
            ACT_READ: begin
              state_d = (idx_ext < COORD_W'(StoreBytes)) ? ST_READ : ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_PIX: begin
        if (pix_info.on_screen) begin
          addr_d  = pix_addr;
          bit_d   = pix_info.bit_sel;
          on_d    = pix_on;
          state_d = ST_RMW;
        end else begin
          b_d = b_next;
          if (act_q == ACT_GLYPH) begin
            row_d = row_adv;
            col_d = col_adv;
          end
          state_d = (b_next == n_q) ? ST_DONE : ST_PIX;
        end
      end

      ST_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = on_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
        inside_d  = inside_q + COUNT_W'(1);
        b_d       = b_next;
        if (act_q == ACT_GLYPH) begin
          row_d = row_adv;
          col_d = col_adv;
        end
        state_d = (b_next == n_q) ? ST_DONE : ST_PIX;
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = src_q;
        if (sweep_q == LastAddr) begin
          sweep_d = '0;
          state_d = ST_DONE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_READ: begin
        rd_d    = mem_rdata;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          read_data_d     = rd_q;
          pixels_inside_d = inside_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      gh_q        <= GH_RESET;
      ox_q        <= '0;
      oy_q        <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      gh_q        <= gh_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    act_q           <= act_d;
    x_q             <= x_d;
    y_q             <= y_d;
    src_q           <= src_d;
    n_q             <= n_d;
    b_q             <= b_d;
    inside_q        <= inside_d;
    addr_q          <= addr_d;
    bit_q           <= bit_d;
    on_q            <= on_d;
    rd_q            <= rd_d;
    read_data_q     <= read_data_d;
    pixels_inside_q <= pixels_inside_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign pixels_inside_o = pixels_inside_q;

  // The write-back of a pixel goes to the byte read in the cycle before.
  `ASSERT_IMPL(a_rmw_same_byte, state_q == ST_RMW, mem_waddr == $past(mem_raddr),
               "pixel write-back address differs from its read address")
  // The inside count never runs ahead of the pixels visited.
  `ASSERT_IMPL(a_inside_bounded, state_q == ST_PIX || state_q == ST_RMW, inside_q <= b_q,
               "inside count exceeds visited pixels")
  // A read result never carries a pixel count.
  `ASSERT_IMPL(a_read_no_count, out_valid_q && read_data_q != '0, pixels_inside_q == '0,
               "result carries both read data and a pixel count")

endmodule

`default_nettype wire

// ----- dv/pmfb_checker.sv -----
`timescale 1ns / 100ps

// Watches the configuration, input and output channels of the frame buffer,
// keeps a shadow copy of the frame store and glyph cursor, and compares every
// output beat with the oldest predicted result.
module pmfb_checker #(
  parameter int SCREEN_WIDTH  = pmfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pmfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [pmfb_pkg::GH_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [pmfb_pkg::ACT_W-1:0]   action_i,
  input  logic [pmfb_pkg::COORD_W-1:0] x_coord_i,
  input  logic [pmfb_pkg::COORD_W-1:0] y_coord_i,
  input  logic [pmfb_pkg::BYTE_W-1:0]  source_byte_i,
  input  logic [pmfb_pkg::COUNT_W-1:0] bit_count_i,
  input  logic                         first_of_glyph_i,
  input  logic [pmfb_pkg::IDX_W-1:0]   byte_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [pmfb_pkg::BYTE_W-1:0]  read_data_i,
  input  logic [pmfb_pkg::COUNT_W-1:0] pixels_inside_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import pmfb_pkg::*;

  localparam int STORE_BYTES = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic [COUNT_W-1:0] pixels_inside;
  } result_t;

  logic [BYTE_W-1:0]  shadow_store [STORE_BYTES];
  logic [COORD_W-1:0] origin_x = '0;
  logic [COORD_W-1:0] origin_y = '0;
  logic [COL_W-1:0]   cursor_col = '0;
  logic [ROW_W-1:0]   cursor_row = '0;
  logic [GH_W-1:0]    glyph_height = GH_RESET;
  result_t            expected_beats [$];
  int                 fails = 0;
  int                 pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Writes one pixel of the shadow store; returns 1 when it lands on screen.
  function automatic int plot(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic on);
    int xi;
    int yi;
    int addr;
    xi = x;
    yi = y;
    if (xi >= SCREEN_WIDTH || yi >= SCREEN_HEIGHT) return 0;
    addr = (yi / 8) * SCREEN_WIDTH + xi;
    if (addr >= STORE_BYTES) return 0;
    shadow_store[addr][yi % 8] = on;
    return 1;
  endfunction

  // Applies one action to the shadow state and returns the result it must produce.
  function automatic result_t draw_and_read(input action_e act,
                                            input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y,
                                            input logic [BYTE_W-1:0] src,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic first,
                                            input logic [IDX_W-1:0] idx);
    result_t r;
    int n;
    int lim;
    int h;
    r = '0;
    n = 0;
    case (act)
      ACT_SET:   n = plot(x, y, 1'b1);
      ACT_CLEAR: n = plot(x, y, 1'b0);
      ACT_COLUMN: begin
        // Low bits first, going down the screen; the y sum wraps at 16 bits.
        lim = (cnt > MAX_BITS) ? int'(MAX_BITS) : int'(cnt);
        for (int b = 0; b < lim; b++) begin
          n += plot(x, y + COORD_W'(b), src[b]);
        end
      end
      ACT_GLYPH: begin
        h = glyph_height;
        if (h < GH_MIN) h = GH_MIN;
        if (h > GH_MAX) h = GH_MAX;
        if (first) begin
          origin_x   = x;
          origin_y   = y;
          cursor_col = '0;
          cursor_row = '0;
        end
        // High bit first; the row wraps at the glyph height and bumps the column.
        for (int b = 0; b < 8; b++) begin
          n += plot(origin_x + COORD_W'(cursor_col), origin_y + COORD_W'(cursor_row),
                    src[int'(GLYPH_MSB) - b]);
          if (int'(cursor_row) + 1 >= h) begin
            cursor_row = '0;
            cursor_col = cursor_col + 1'b1;
          end else begin
            cursor_row = cursor_row + 1'b1;
          end
        end
      end
      ACT_FILL: begin
        foreach (shadow_store[i]) shadow_store[i] = src;
      end
      ACT_READ: begin
        if (int'(idx) < STORE_BYTES) r.read_data = shadow_store[idx];
      end
      default: begin
        // Unused codes leave everything untouched.
      end
    endcase
    r.pixels_inside = COUNT_W'(n);
    return r;
  endfunction

  // Shadow state update on accepted beats, and comparison of output beats.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t got;
    result_t want;
    if (!rst_ni) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      origin_x     = '0;
      origin_y     = '0;
      cursor_col   = '0;
      cursor_row   = '0;
      glyph_height = GH_RESET;
      expected_beats.delete();
      pending = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) glyph_height = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        expected_beats.push_back(draw_and_read(action_e'(action_i), x_coord_i, y_coord_i,
                                               source_byte_i, bit_count_i,
                                               first_of_glyph_i, byte_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got.read_data     = read_data_i;
        got.pixels_inside = pixels_inside_i;
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: read_data %0h, pixels_inside %0d",
                 got.read_data, got.pixels_inside);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0h, actual %0h",
                   want.read_data, got.read_data);
            fails++;
          end
          if (got.pixels_inside !== want.pixels_inside) begin
            $error("pixels_inside mismatch: expected %0d, actual %0d",
                   want.pixels_inside, got.pixels_inside);
            fails++;
          end
        end
      end
      pending = expected_beats.size();
    end
  end

endmodule

// ----- dv/tb_page_mode_pixel_framebuffer.sv -----
`timescale 1ns / 100ps

module tb_page_mode_pixel_framebuffer;
  import pmfb_pkg::*;

  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 244;
  localparam int STORE_BYTES      = DEF_SCREEN_WIDTH * (DEF_SCREEN_HEIGHT / 8);
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 24;

  // Action codes the block does not define.
  localparam logic [ACT_W-1:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [BYTE_W-1:0] FILL_ALL_ON  = 8'hFF;
  localparam logic [BYTE_W-1:0] FILL_ALL_OFF = 8'h00;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BYTE_W-1:0]  src;
    logic [COUNT_W-1:0] cnt;
    logic               first;
    logic [IDX_W-1:0]   idx;
  } draw_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [GH_W-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   action = '0;
  logic [COORD_W-1:0] x_coord = '0;
  logic [COORD_W-1:0] y_coord = '0;
  logic [BYTE_W-1:0]  source_byte = '0;
  logic [COUNT_W-1:0] bit_count = '0;
  logic               first_of_glyph = 1'b0;
  logic [IDX_W-1:0]   byte_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  read_data;
  logic [COUNT_W-1:0] pixels_inside;
  int                 fail_count;
  int                 pending;
  bit                 long_hold_req = 1'b0;
  bit                 steady_tx = 1'b0;
  int                 recent_idx = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  page_mode_pixel_framebuffer u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .x_coord_i        (x_coord),
    .y_coord_i        (y_coord),
    .source_byte_i    (source_byte),
    .bit_count_i      (bit_count),
    .first_of_glyph_i (first_of_glyph),
    .byte_index_i     (byte_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_data_o      (read_data),
    .pixels_inside_o  (pixels_inside)
  );

  pmfb_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .action_i         (action),
    .x_coord_i        (x_coord),
    .y_coord_i        (y_coord),
    .source_byte_i    (source_byte),
    .bit_count_i      (bit_count),
    .first_of_glyph_i (first_of_glyph),
    .byte_index_i     (byte_index),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .read_data_i      (read_data),
    .pixels_inside_i  (pixels_inside),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  function automatic draw_req_t mk(input logic [ACT_W-1:0] a, input int x, input int y,
                                   input int src, input int cnt, input bit first,
                                   input int idx);
    draw_req_t r;
    r.action = a;
    r.x      = COORD_W'(x);
    r.y      = COORD_W'(y);
    r.src    = BYTE_W'(src);
    r.cnt    = COUNT_W'(cnt);
    r.first  = first;
    r.idx    = IDX_W'(idx);
    return r;
  endfunction

  // Mostly on or just past the screen, sometimes just below the 16-bit wrap.
  function automatic logic [COORD_W-1:0] rand_coord(input int span);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return COORD_W'($urandom_range(0, span + 7));
    if (sel < 85) return COORD_W'($urandom_range(65528, 65535));
    return COORD_W'($urandom_range(0, 65535));
  endfunction

  // Random content for every field; reads favor bytes that were drawn lately.
  function automatic draw_req_t rand_req(input logic [ACT_W-1:0] act);
    draw_req_t r;
    r.action = act;
    r.x      = rand_coord(DEF_SCREEN_WIDTH);
    r.y      = rand_coord(DEF_SCREEN_HEIGHT);
    r.src    = BYTE_W'($urandom);
    r.cnt    = ($urandom_range(0, 4) != 0) ? COUNT_W'($urandom_range(1, 8))
                                           : COUNT_W'($urandom_range(0, 15));
    r.first  = 1'($urandom_range(0, 1));
    r.idx    = $urandom_range(0, 1) ? IDX_W'(recent_idx)
                                    : IDX_W'($urandom_range(0, STORE_BYTES - 1));
    if (r.x < DEF_SCREEN_WIDTH && r.y < DEF_SCREEN_HEIGHT) begin
      recent_idx = (int'(r.y) / 8) * DEF_SCREEN_WIDTH + int'(r.x);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    if (steady_tx) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one beat, holds it until accepted, then maybe idles a while.
  task automatic send_req(input draw_req_t r);
    int gap;
    @(negedge clk);
    action         <= r.action;
    x_coord        <= r.x;
    y_coord        <= r.y;
    source_byte    <= r.src;
    bit_count      <= r.cnt;
    first_of_glyph <= r.first;
    byte_index     <= r.idx;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_height(input logic [GH_W-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic; glyph bytes mostly come in started runs, with some broken ones.
  task automatic run_phase(input int items);
    int n;
    int sel;
    int run;
    draw_req_t r;
    n = 0;
    while (n < items) begin
      steady_tx = (n < 30);
      sel = $urandom_range(0, 99);
      if (sel < 30 && sel >= 0 && sel >= 0 && sel < 30 && sel >= 0 && sel < 30 &&
          sel < 30) begin
        run = $urandom_range(1, 12);
        for (int k = 0; k < run; k++) begin
          r = rand_req(ACT_GLYPH);
          r.first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
          send_req(r);
          n++;
        end
      end else begin
        if (sel < 40)      r = rand_req(ACT_SET);
        else if (sel < 48) r = rand_req(ACT_CLEAR);
        else if (sel < 70) r = rand_req(ACT_COLUMN);
        else if (sel < 97) r = rand_req(ACT_READ);
        else if (sel < 98) r = rand_req(ACT_FILL);
        else               r = rand_req($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI);
        send_req(r);
        n++;
      end
    end
    steady_tx = 1'b0;
  endtask

  // Output-side back-pressure: short and long stalls, quiet stretches, and one
  // long hold-off that backs the block up while items keep being offered.
  initial begin : rx_pacing
    int hold;
    int go;
    int sel;
    bit long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold = LONG_HOLD_CYCLES;
      end else begin
        sel = $urandom_range(0, 99);
        hold = (sel < 65) ? 0 : (sel < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      go = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 6);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat (go - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    draw_req_t directed [$];
    logic [GH_W-1:0] heights [PHASES];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats run with the reset glyph height.
    directed.push_back(mk(ACT_READ,   0, 0, 8'h00, 0, 1'b0, 0));
    directed.push_back(mk(ACT_SET,    0, 0, 8'hFF, 15, 1'b1, 1023));
    directed.push_back(mk(ACT_SET,    DEF_SCREEN_WIDTH - 1, DEF_SCREEN_HEIGHT - 1, 0, 0, 0, 0));
    directed.push_back(mk(ACT_SET,    DEF_SCREEN_WIDTH, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_SET,    0, DEF_SCREEN_HEIGHT, 0, 0, 0, 0));
    directed.push_back(mk(ACT_SET,    16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
    directed.push_back(mk(ACT_CLEAR,  0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_COLUMN, 5, 3, 8'hA5, 8, 0, 0));
    // Bit count above eight draws eight, and the y sum wraps onto the top rows.
    directed.push_back(mk(ACT_COLUMN, 6, 16'hFFFC, 8'hFF, 15, 0, 0));
    directed.push_back(mk(ACT_COLUMN, 7, 7, 8'hFF, 0, 0, 0));
    directed.push_back(mk(ACT_COLUMN, DEF_SCREEN_WIDTH - 1, 60, 8'h5A, 9, 0, 0));
    // A glyph byte with no start since reset continues from the reset cursor.
    directed.push_back(mk(ACT_GLYPH,  40, 40, 8'hC3, 0, 0, 0));
    directed.push_back(mk(ACT_GLYPH,  10, 8, 8'hFF, 0, 1, 0));
    directed.push_back(mk(ACT_GLYPH,  0, 0, 8'h81, 0, 0, 0));
    directed.push_back(mk(ACT_GLYPH,  DEF_SCREEN_WIDTH - 2, DEF_SCREEN_HEIGHT - 2, 8'hF0,
                          0, 1, 0));
    directed.push_back(mk(ACT_GLYPH,  16'hFFFF, 0, 8'hFF, 0, 1, 0));
    directed.push_back(mk(ACT_GLYPH,  0, 0, 8'h3C, 0, 0, 0));
    directed.push_back(mk(ACT_READ,   0, 0, 0, 0, 0, 0));
    directed.push_back(mk(ACT_READ,   0, 0, 0, 0, 0, STORE_BYTES - 1));
    directed.push_back(mk(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hFF, 15, 1, 1023));
    directed.push_back(mk(ACT_SPARE_HI, 3, 3, 8'h0F, 4, 0, 2));
    directed.push_back(mk(ACT_FILL,   0, 0, FILL_ALL_ON, 0, 0, 0));
    directed.push_back(mk(ACT_READ,   0, 0, 0, 0, 0, 517));
    directed.push_back(mk(ACT_COLUMN, 0, 0, 8'h00, 8, 0, 0));
    directed.push_back(mk(ACT_FILL,   0, 0, FILL_ALL_OFF, 0, 0, 0));
    foreach (directed[i]) send_req(directed[i]);
    wait_idle();

    heights = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd5, 7'd8, 7'd13};
    heights[PHASES - 1] = GH_W'($urandom_range(1, 64));
    for (int p = 0; p < PHASES; p++) begin
      write_height(heights[p]);
      if (p == 2) long_hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pmfb_pkg.sv
rtl/core/pmfb_store.sv
rtl/core/pmfb_pix_unit.sv
rtl/core/page_mode_pixel_framebuffer.sv
dv/pmfb_checker.sv
dv/tb_page_mode_pixel_framebuffer.sv
